// ===== rtl/core/prq_pkg.sv =====
package prq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Fixed port field widths
   localparam int PORT_ID_BITS    = 8;
   localparam int PORT_COUNT_BITS = 5;

   // Function codes and flag values
   localparam logic FUNC_ENQUEUE   = 1'b0;
   localparam logic FUNC_SCHEDULE  = 1'b1;
   localparam logic HIGH_PRIO      = 1'b1;
   localparam logic KEEP_RUNNING   = 1'b1;

   typedef logic [ID_BITS-1:0]         id_type;
   typedef logic [COUNT_BITS-1:0]      count_type;
   typedef logic [PORT_ID_BITS-1:0]    port_id_type;
   typedef logic [PORT_COUNT_BITS-1:0] port_count_type;

   typedef struct packed {
      id_type id;
      logic   high;
   } entry_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic occ;       // cell holds a waiting entry
      logic tail_wr;   // cell is the tail slot and takes the pushed entry
      logic pick;      // selection cycle of a schedule beat
      logic any_high;  // some waiting entry has high priority
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_PICK
   } state_type;

endpackage

// ===== rtl/core/prq_cell.sv =====
module prq_cell (
   input  logic                   clock,
   input  prq_pkg::cell_ctrl_type ctrl,
   input  prq_pkg::entry_type     tail_entry,
   input  prq_pkg::entry_type     next_entry,
   input  logic                   seen_in,
   output logic                   seen_out,
   output logic                   hit,
   output prq_pkg::entry_type     entry_out
);

   prq_pkg::entry_type entry_ff;
   logic               is_high;
   logic               take;

   assign is_high   = ctrl.occ & (entry_ff.high == prq_pkg::HIGH_PRIO);
   assign hit       = is_high & ~seen_in;
   assign seen_out  = seen_in | is_high;
   // close the gap: every cell from the selected one on takes its neighbor
   assign take      = ctrl.pick & (~ctrl.any_high | seen_out);
   assign entry_out = entry_ff;

   always_ff @(posedge clock) begin
      if (ctrl.tail_wr) begin
         entry_ff <= tail_entry;
      end else if (take) begin
         entry_ff <= next_entry;
      end
   end

endmodule

// ===== rtl/core/priority_bypass_ready_queue.sv =====
// Ready queue of thread ids with a high-priority bypass and the running thread.
// Input channel req_*: one beat per operation. req_func selects enqueue
// (append req_thread_id / req_high_priority at the tail) or schedule (requeue
// the running thread if req_current_runs, then take the oldest high-priority
// entry, or the head if none, and make it the running thread).
// Result channel rsp_*: exactly one beat per request beat, in order, carrying
// the running id, picked and dropped flags and the queue fill after the op.
// Timing: an enqueue result is valid the cycle after acceptance; a schedule
// result is registered after the pick state, which selects and shifts the cell row.
// Throughput: one enqueue every cycle while results are taken; a schedule
// holds off requests during its single selection pass through the cell row.
// A full queue drops the pushed entry and raises rsp_dropped.
// Reset (synchronous, active high) empties the queue and makes thread 0 the
// running thread at normal priority; queue storage itself is not cleared.
// When the receiver stalls, the result holds in the output register and
// req_ready stays low until it is taken or taken in the same cycle.
module priority_bypass_ready_queue (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_thread_id,
   input  logic       req_high_priority,
   input  logic       req_current_runs,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_running_id,
   output logic       rsp_picked,
   output logic       rsp_dropped,
   output logic [4:0] rsp_queued_count
);

   localparam int Depth = prq_pkg::QUEUE_DEPTH;

   prq_pkg::state_type      state_ff, state_in;
   prq_pkg::count_type      fill_ff, fill_in;
   prq_pkg::entry_type      cur_ff, cur_in;
   logic                    drop_ff, drop_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   prq_pkg::port_id_type    rsp_id_ff, rsp_id_in;
   logic                    rsp_picked_ff, rsp_picked_in;
   logic                    rsp_dropped_ff, rsp_dropped_in;
   prq_pkg::port_count_type rsp_count_ff, rsp_count_in;

   logic                    accept;
   logic                    push_req;
   logic                    full;
   logic                    push_ok;
   logic                    pick;
   logic                    any_high;
   prq_pkg::entry_type      push_entry;
   prq_pkg::entry_type      sel_entry;

   prq_pkg::cell_ctrl_type  ctrl     [Depth];
   prq_pkg::entry_type      entries  [Depth];
   prq_pkg::entry_type      next_ent [Depth];
   logic                    hits     [Depth];
   logic [Depth:0]          seen;

   // Handshake: take a beat only when idle and the output slot frees up
   assign req_ready = (state_ff == prq_pkg::ST_IDLE) & (~rsp_valid_ff | rsp_ready);
   assign accept    = req_valid & req_ready;

   // Tail push: the enqueued entry or the requeued running thread
   assign push_entry = (req_func == prq_pkg::FUNC_ENQUEUE)
                       ? prq_pkg::entry_type'{id:   prq_pkg::id_type'(req_thread_id),
                                              high: req_high_priority}
                       : cur_ff;
   assign push_req   = accept & ((req_func == prq_pkg::FUNC_ENQUEUE) |
                                 (req_current_runs == prq_pkg::KEEP_RUNNING));
   assign full       = (fill_ff == prq_pkg::count_type'(Depth));
   assign push_ok    = push_req & ~full;

   // Selection happens in the pick cycle if anything waits
   assign pick     = (state_ff == prq_pkg::ST_PICK) & (fill_ff != '0);
   assign seen[0]  = 1'b0;
   assign any_high = seen[Depth];

   // Row of cells; entries ripple toward the head on a pick
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      assign ctrl[i].occ      = prq_pkg::count_type'(i) < fill_ff;
      assign ctrl[i].tail_wr  = push_ok & (fill_ff == prq_pkg::count_type'(i));
      assign ctrl[i].pick     = pick;
      assign ctrl[i].any_high = any_high;

      if (i == Depth - 1) begin : g_last
         assign next_ent[i] = entries[i];
      end else begin : g_mid
         assign next_ent[i] = entries[i+1];
      end

      prq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[i]),
         .tail_entry (push_entry),
         .next_entry (next_ent[i]),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .hit        (hits[i]),
         .entry_out  (entries[i])
      );
   end

   // Gather the chosen entry: first high-priority cell, else the head
   always_comb begin
      sel_entry = any_high ? '0 : entries[0];
      for (int i = 0; i < Depth; i++) begin
         if (hits[i]) begin
            sel_entry = sel_entry | entries[i];
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (accept && req_func == prq_pkg::FUNC_SCHEDULE) begin
               state_in = prq_pkg::ST_PICK;
            end
         end
         prq_pkg::ST_PICK: begin
            state_in = prq_pkg::ST_IDLE;
         end
         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and result register
   always_comb begin
      fill_in        = fill_ff;
      cur_in         = cur_ff;
      drop_in        = drop_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_id_in      = rsp_id_ff;
      rsp_picked_in  = rsp_picked_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_count_in   = rsp_count_ff;
      unique case (state_ff)
         prq_pkg::ST_IDLE: begin
            if (accept) begin
               if (push_ok) begin
                  fill_in = fill_ff + prq_pkg::count_type'(1);
               end
               drop_in = push_req & full;
               if (req_func == prq_pkg::FUNC_ENQUEUE) begin
                  // enqueue answers at once
                  rsp_valid_in   = 1'b1;
                  rsp_id_in      = prq_pkg::port_id_type'(cur_ff.id);
                  rsp_picked_in  = 1'b0;
                  rsp_dropped_in = push_req & full;
                  rsp_count_in   = prq_pkg::port_count_type'(
                                      push_ok ? fill_ff + prq_pkg::count_type'(1) : fill_ff);
               end
            end
         end
         prq_pkg::ST_PICK: begin
            if (pick) begin
               cur_in  = sel_entry;
               fill_in = fill_ff - prq_pkg::count_type'(1);
            end
            rsp_valid_in   = 1'b1;
            rsp_id_in      = prq_pkg::port_id_type'(pick ? sel_entry.id : cur_ff.id);
            rsp_picked_in  = pick;
            rsp_dropped_in = drop_ff;
            rsp_count_in   = prq_pkg::port_count_type'(
                                pick ? fill_ff - prq_pkg::count_type'(1) : fill_ff);
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prq_pkg::ST_IDLE;
         fill_ff      <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold until taken
   always_ff @(posedge clock) begin
      drop_ff        <= drop_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_picked_ff  <= rsp_picked_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_id   = rsp_id_ff;
   assign rsp_picked       = rsp_picked_ff;
   assign rsp_dropped      = rsp_dropped_ff;
   assign rsp_queued_count = rsp_count_ff;

endmodule

// ===== tb/priority_bypass_ready_queue_tb.sv =====
`timescale 1ns / 1ps

module priority_bypass_ready_queue_tb;

   // A run with no accepted beat on either channel for this many cycles is hung
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS   = 900;

   // One result beat as the block should present it
   typedef struct {
      prq_pkg::port_id_type    running_id;
      logic                    picked;
      logic                    dropped;
      prq_pkg::port_count_type queued_count;
   } sched_outcome_type;

   // Ready-queue scoreboard: mirror the queue, the running thread and the
   // outcomes still owed by the block.
   class ready_queue_scoreboard;
      prq_pkg::entry_type waiting[$];
      prq_pkg::id_type    running_id   = '0;
      logic               running_high = 1'b0;
      sched_outcome_type  owed[$];
      int errors       = 0;
      int checked      = 0;
      int enqueues     = 0;
      int schedules    = 0;
      int drops        = 0;
      int empty_picks  = 0;
      int bypass_picks = 0;

      // Append at the tail; return 1 when the queue is full and the entry is lost.
      function logic push_tail(prq_pkg::id_type id, logic high);
         prq_pkg::entry_type e;
         if (waiting.size() >= prq_pkg::QUEUE_DEPTH) begin
            drops++;
            return 1'b1;
         end
         e.id   = id;
         e.high = high;
         waiting.push_back(e);
         return 1'b0;
      endfunction

      function void note_request(logic func, prq_pkg::port_id_type tid, logic high,
                                 logic runs);
         sched_outcome_type o;
         int pos;
         o.picked  = 1'b0;
         o.dropped = 1'b0;
         if (func == prq_pkg::FUNC_ENQUEUE) begin
            enqueues++;
            o.dropped = push_tail(prq_pkg::id_type'(tid), high);
         end else begin
            schedules++;
            if (runs == prq_pkg::KEEP_RUNNING)
               o.dropped = push_tail(running_id, running_high);
            if (waiting.size() > 0) begin
               // oldest high-priority entry wins, else the head
               pos = 0;
               for (int i = waiting.size() - 1; i >= 0; i--)
                  if (waiting[i].high == prq_pkg::HIGH_PRIO) pos = i;
               if (pos != 0) bypass_picks++;
               running_id   = waiting[pos].id;
               running_high = waiting[pos].high;
               waiting.delete(pos);
               o.picked = 1'b1;
            end else begin
               empty_picks++;
            end
         end
         o.running_id   = prq_pkg::port_id_type'(running_id);
         o.queued_count = prq_pkg::port_count_type'(waiting.size());
         owed.push_back(o);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(prq_pkg::port_id_type id, logic picked, logic dropped,
                                 prq_pkg::port_count_type count);
         sched_outcome_type o;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, actual running_id %0d count %0d",
                     $time, id, count);
            return;
         end
         o = owed.pop_front();
         checked++;
         compare_field("running_id", o.running_id, id);
         compare_field("picked", o.picked, picked);
         compare_field("dropped", o.dropped, dropped);
         compare_field("queued_count", o.queued_count, count);
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_func;
   prq_pkg::port_id_type    req_thread_id;
   logic                    req_high_priority;
   logic                    req_current_runs;
   logic                    rsp_valid;
   logic                    rsp_ready;
   prq_pkg::port_id_type    rsp_running_id;
   logic                    rsp_picked;
   logic                    rsp_dropped;
   prq_pkg::port_count_type rsp_queued_count;

   // Suppress idling on both channels while set
   logic steady = 1'b0;
   int   quiet_cycles = 0;

   ready_queue_scoreboard board = new;

   priority_bypass_ready_queue u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_thread_id     (req_thread_id),
      .req_high_priority (req_high_priority),
      .req_current_runs  (req_current_runs),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_running_id    (rsp_running_id),
      .rsp_picked        (rsp_picked),
      .rsp_dropped       (rsp_dropped),
      .rsp_queued_count  (rsp_queued_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one request beat and hold it until the block takes it. An optional
   // idle gap goes in front; valid is only ever set once per time step.
   task automatic send_request(input logic func, input prq_pkg::port_id_type tid,
                               input logic high, input logic runs);
      if (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_thread_id     <= tid;
      req_high_priority <= high;
      req_current_runs  <= runs;
      do @(posedge clock); while (!req_ready);
      board.note_request(func, tid, high, runs);
   endtask

   task automatic enqueue_thread(input prq_pkg::port_id_type tid, input logic high);
      send_request(prq_pkg::FUNC_ENQUEUE, tid, high, 1'($urandom_range(1)));
   endtask

   task automatic schedule_thread(input logic runs);
      send_request(prq_pkg::FUNC_SCHEDULE, 8'($urandom_range(255)),
                   1'($urandom_range(1)), runs);
   endtask

   // Receiver: stall on about 11 percent of cycles, never while steady
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= steady || ($urandom_range(99) >= 11);
      end
   end

   // Check every accepted result beat against the oldest owed outcome
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_running_id, rsp_picked, rsp_dropped, rsp_queued_count);
   end

   // Watchdog: count cycles in which neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int enq_pct;
      int high_pct;
      logic func;

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_func          <= prq_pkg::FUNC_ENQUEUE;
      req_thread_id     <= '0;
      req_high_priority <= 1'b0;
      req_current_runs  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: schedule on the empty queue, first with the boot thread
      // blocked (it stays on), then still running (requeued and picked again)
      schedule_thread(1'b0);
      schedule_thread(prq_pkg::KEEP_RUNNING);
      // Id extremes at both priorities, then bypass past normal entries
      enqueue_thread(8'd255, prq_pkg::HIGH_PRIO);
      enqueue_thread(8'd0, 1'b0);
      enqueue_thread(8'hAA, 1'b0);
      enqueue_thread(8'h55, prq_pkg::HIGH_PRIO);
      schedule_thread(prq_pkg::KEEP_RUNNING);
      schedule_thread(1'b0);
      schedule_thread(prq_pkg::KEEP_RUNNING);
      // Fill to the brim with one high entry near the tail, then overflow
      for (int i = 0; i < 13; i++)
         enqueue_thread(prq_pkg::port_id_type'(16 + i), i == 12);
      enqueue_thread(8'hF0, prq_pkg::HIGH_PRIO);
      enqueue_thread(8'h0F, 1'b0);
      // Requeue onto a full queue: drop the running thread, still pick
      schedule_thread(prq_pkg::KEEP_RUNNING);

      // Random: blocks with their own enqueue/schedule mix and priority density
      // so the queue swings between empty and full; one long stretch runs with
      // no idling on either side.
      enq_pct  = 50;
      high_pct = 20;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(4))
               0: enq_pct = 15;
               1: enq_pct = 35;
               2: enq_pct = 50;
               3: enq_pct = 65;
               default: enq_pct = 85;
            endcase
            case ($urandom_range(3))
               0: high_pct = 0;
               1: high_pct = 20;
               2: high_pct = 50;
               default: high_pct = 100;
            endcase
         end
         steady <= (n >= 300 && n < 450);
         func = ($urandom_range(99) < enq_pct) ? prq_pkg::FUNC_ENQUEUE
                                               : prq_pkg::FUNC_SCHEDULE;
         if (func == prq_pkg::FUNC_ENQUEUE)
            enqueue_thread(8'($urandom_range(255)), $urandom_range(99) < high_pct);
         else
            schedule_thread(1'($urandom_range(1)));
      end

      // Drain: release valid, wait for every owed result, then let the
      // pipeline settle so a stray extra beat would be seen
      req_valid <= 1'b0;
      steady    <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("summary: %0d request beats (%0d enqueue, %0d schedule), %0d results checked",
               board.enqueues + board.schedules, board.enqueues, board.schedules,
               board.checked);
      $display("summary: %0d entries lost to a full queue, %0d schedules found it empty, %0d %s",
               board.drops, board.empty_picks, board.bypass_picks, "bypass picks");
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== priority_bypass_ready_queue.f =====
rtl/core/prq_pkg.sv
rtl/core/prq_cell.sv
rtl/core/priority_bypass_ready_queue.sv
tb/priority_bypass_ready_queue_tb.sv
